### design/gsa_pkg.sv
`default_nettype none
package gsa_pkg;

  localparam int MAX_NODES = 4096;
  localparam int ALPHABET  = 26;
  localparam int SYM_W     = 5;
  localparam int NODE_W    = 12;
  localparam int CNT_W     = 13;
  localparam int TOT_W     = 22;
  localparam int TT_DEPTH  = MAX_NODES * ALPHABET;
  localparam int TT_AW     = $clog2(TT_DEPTH);
  localparam int IDX_W     = $clog2(ALPHABET + 1);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_RD_P, ST_WT_P, ST_RD_Q, ST_WT_Q, ST_NEW, ST_CLR,
    ST_WALK_W, ST_WALK_L, ST_CLONE, ST_CP_LNK, ST_COPY, ST_RED_W, ST_RED_L,
    ST_RED_RD, ST_RED_WT, ST_RED_END, ST_TOT, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR_ROOT, OP_START, OP_READ_P, OP_LATCH_P, OP_READ_Q,
    OP_Q_MATCH, OP_NEW, OP_CLR, OP_WALK_SET, OP_FOLLOW, OP_CLONE,
    OP_CP_LNK, OP_COPY, OP_RED_SET, OP_RED_READ, OP_RED_END, OP_TOT, OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic tt_hit;
    logic q_match;
    logic p_zero;
    logic is_new;
    logic idx_last;
    logic copy_last;
    logic red_hit;
  } status_t;

  function automatic logic [TT_AW-1:0] tt_addr(logic [NODE_W-1:0] node,
                                               logic [IDX_W-1:0] col);
    return TT_AW'(node) * TT_AW'(ALPHABET) + TT_AW'(col);
  endfunction

endpackage
`default_nettype wire

### design/gsa_ctrl.sv
`default_nettype none
module gsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire gsa_pkg::status_t st,
  output gsa_pkg::cmd_t        cmd
);

  gsa_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsa_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign load = (state_r == gsa_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsa_pkg::ST_INIT:    if (st.idx_last) state_nxt = gsa_pkg::ST_IDLE;
      gsa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = st.skip ? gsa_pkg::ST_FIN : gsa_pkg::ST_RD_P;
      end
      gsa_pkg::ST_RD_P:    state_nxt = gsa_pkg::ST_WT_P;
      gsa_pkg::ST_WT_P: begin
        if (st.tt_hit)      state_nxt = gsa_pkg::ST_RD_Q;
        else if (st.is_new) state_nxt = gsa_pkg::ST_WALK_W;
        else                state_nxt = gsa_pkg::ST_NEW;
      end
      gsa_pkg::ST_RD_Q:    state_nxt = gsa_pkg::ST_WT_Q;
      gsa_pkg::ST_WT_Q: begin
        if (st.q_match) state_nxt = st.is_new ? gsa_pkg::ST_TOT : gsa_pkg::ST_FIN;
        else            state_nxt = gsa_pkg::ST_CLONE;
      end
      gsa_pkg::ST_NEW:     state_nxt = gsa_pkg::ST_CLR;
      gsa_pkg::ST_CLR:     if (st.idx_last) state_nxt = gsa_pkg::ST_WALK_W;
      gsa_pkg::ST_WALK_W:  state_nxt = st.p_zero ? gsa_pkg::ST_TOT : gsa_pkg::ST_WALK_L;
      gsa_pkg::ST_WALK_L:  state_nxt = gsa_pkg::ST_RD_P;
      gsa_pkg::ST_CLONE:   state_nxt = gsa_pkg::ST_CP_LNK;
      gsa_pkg::ST_CP_LNK:  state_nxt = gsa_pkg::ST_COPY;
      gsa_pkg::ST_COPY:    if (st.copy_last) state_nxt = gsa_pkg::ST_RED_W;
      gsa_pkg::ST_RED_W:   state_nxt = st.p_zero ? gsa_pkg::ST_RED_END : gsa_pkg::ST_RED_L;
      gsa_pkg::ST_RED_L:   state_nxt = gsa_pkg::ST_RED_RD;
      gsa_pkg::ST_RED_RD:  state_nxt = gsa_pkg::ST_RED_WT;
      gsa_pkg::ST_RED_WT:  state_nxt = st.red_hit ? gsa_pkg::ST_RED_W : gsa_pkg::ST_RED_END;
      gsa_pkg::ST_RED_END: state_nxt = st.is_new ? gsa_pkg::ST_TOT : gsa_pkg::ST_FIN;
      gsa_pkg::ST_TOT:     state_nxt = gsa_pkg::ST_FIN;
      gsa_pkg::ST_FIN:     if (load) state_nxt = gsa_pkg::ST_IDLE;
      default:             state_nxt = gsa_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd.op = gsa_pkg::OP_NOP;
    case (state_r)
      gsa_pkg::ST_INIT:    cmd.op = gsa_pkg::OP_CLR_ROOT;
      gsa_pkg::ST_IDLE:    if (in_valid) cmd.op = gsa_pkg::OP_START;
      gsa_pkg::ST_RD_P:    cmd.op = gsa_pkg::OP_READ_P;
      gsa_pkg::ST_WT_P:    cmd.op = gsa_pkg::OP_LATCH_P;
      gsa_pkg::ST_RD_Q:    cmd.op = gsa_pkg::OP_READ_Q;
      gsa_pkg::ST_WT_Q:    if (st.q_match) cmd.op = gsa_pkg::OP_Q_MATCH;
      gsa_pkg::ST_NEW:     cmd.op = gsa_pkg::OP_NEW;
      gsa_pkg::ST_CLR:     cmd.op = gsa_pkg::OP_CLR;
      gsa_pkg::ST_WALK_W:  cmd.op = gsa_pkg::OP_WALK_SET;
      gsa_pkg::ST_WALK_L:  cmd.op = gsa_pkg::OP_FOLLOW;
      gsa_pkg::ST_CLONE:   cmd.op = gsa_pkg::OP_CLONE;
      gsa_pkg::ST_CP_LNK:  cmd.op = gsa_pkg::OP_CP_LNK;
      gsa_pkg::ST_COPY:    cmd.op = gsa_pkg::OP_COPY;
      gsa_pkg::ST_RED_W:   cmd.op = gsa_pkg::OP_RED_SET;
      gsa_pkg::ST_RED_L:   cmd.op = gsa_pkg::OP_FOLLOW;
      gsa_pkg::ST_RED_RD:  cmd.op = gsa_pkg::OP_RED_READ;
      gsa_pkg::ST_RED_WT:  cmd.op = gsa_pkg::OP_NOP;
      gsa_pkg::ST_RED_END: cmd.op = gsa_pkg::OP_RED_END;
      gsa_pkg::ST_TOT:     cmd.op = gsa_pkg::OP_TOT;
      gsa_pkg::ST_FIN:     if (load) cmd.op = gsa_pkg::OP_LOAD;
      default:             cmd.op = gsa_pkg::OP_NOP;
    endcase
  end

  assign in_stall  = (state_r != gsa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && state_r == gsa_pkg::ST_IDLE)
    else $error("finished transaction not presented");
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gsa_pkg::ST_INIT |-> in_stall)
    else $error("input taken before root row cleared");
  a_copy_to_redirect: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gsa_pkg::ST_COPY && st.copy_last |=> state_r == gsa_pkg::ST_RED_W)
    else $error("row copy did not hand over to redirect");

endmodule
`default_nettype wire

### design/gsa_dpath.sv
`default_nettype none
module gsa_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gsa_pkg::cmd_t               cmd,
  output gsa_pkg::status_t                 st,
  input  wire logic [gsa_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic                        in_first_of_string,
  output logic [gsa_pkg::NODE_W-1:0]       out_reached_node,
  output logic [gsa_pkg::CNT_W-1:0]        out_nodes_used,
  output logic [gsa_pkg::TOT_W-1:0]        out_distinct_substrings,
  output logic                             out_table_full
);

  localparam int NW = gsa_pkg::NODE_W;
  localparam int CW = gsa_pkg::CNT_W;
  localparam int TW = gsa_pkg::TOT_W;
  localparam int AW = gsa_pkg::TT_AW;
  localparam int IW = gsa_pkg::IDX_W;
  localparam int SYM_WL = gsa_pkg::SYM_W;

  logic [NW:0]   tt_mem [gsa_pkg::TT_DEPTH];
  logic [NW-1:0] lnk_mem [gsa_pkg::MAX_NODES];
  logic [NW-1:0] len_mem [gsa_pkg::MAX_NODES];

  logic          tt_we, tt_re, lnk_we, lnk_re, len_we, len_re;
  logic [AW-1:0] tt_waddr, tt_raddr;
  logic [NW:0]   tt_wdata;
  logic [NW-1:0] lnk_waddr, lnk_raddr, lnk_wdata, len_waddr, len_raddr, len_wdata;
  logic [NW:0]   tt_rd_r;
  logic [NW-1:0] lnk_rd_r, len_rd_r;

  logic [CW-1:0] nodes_r, nodes_nxt;
  logic [NW-1:0] curnode_r, curnode_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [SYM_WL-1:0] c_r, c_nxt;
  logic [NW-1:0] p_r, p_nxt, q_r, q_nxt, k_r, k_nxt, cur_r, cur_nxt;
  logic [NW-1:0] lenp_r, lenp_nxt, lencur_r, lencur_nxt, lnkcur_r, lnkcur_nxt;
  logic          full_r, full_nxt, new_r, new_nxt, found_r, found_nxt;
  logic [NW-1:0] ro_node_r, ro_node_nxt;
  logic [CW-1:0] ro_nodes_r, ro_nodes_nxt;
  logic [TW-1:0] ro_total_r, ro_total_nxt;
  logic          ro_full_r, ro_full_nxt;

  logic          full_cond, sym_ok;
  logic [NW-1:0] p_start, lenp_inc;
  logic [NW:0]   sub_w, add_w;
  logic [TW:0]   sum_w;
  logic [NW-1:0] col_idx;

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
    if (tt_re) tt_rd_r <= tt_mem[tt_raddr];
    if (lnk_we) lnk_mem[lnk_waddr] <= lnk_wdata;
    if (lnk_re) lnk_rd_r <= lnk_mem[lnk_raddr];
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (len_re) len_rd_r <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r   <= CW'(1);
      curnode_r <= '0;
      total_r   <= '0;
      idx_r     <= '0;
      new_r     <= 1'b0;
      found_r   <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      nodes_r   <= nodes_nxt;
      curnode_r <= curnode_nxt;
      total_r   <= total_nxt;
      idx_r     <= idx_nxt;
      new_r     <= new_nxt;
      found_r   <= found_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    lenp_r     <= lenp_nxt;
    lencur_r   <= lencur_nxt;
    lnkcur_r   <= lnkcur_nxt;
    ro_node_r  <= ro_node_nxt;
    ro_nodes_r <= ro_nodes_nxt;
    ro_total_r <= ro_total_nxt;
    ro_full_r  <= ro_full_nxt;
  end

  assign sym_ok    = ({1'b0, in_symbol} < (SYM_WL + 1)'(gsa_pkg::ALPHABET));
  assign full_cond = ({1'b0, nodes_r} + (CW + 1)'(2)) > (CW + 1)'(gsa_pkg::MAX_NODES);
  assign p_start   = (in_first_of_string || ({1'b0, curnode_r} >= nodes_r)) ? '0 : curnode_r;
  assign lenp_inc  = lenp_r + NW'(1);
  assign col_idx   = NW'(c_r);
  assign sub_w     = found_r ? ({1'b0, lenp_r} + (NW + 1)'(1)) : '0;
  assign add_w     = {1'b0, lencur_r} - sub_w;
  assign sum_w     = {1'b0, total_r} + (TW + 1)'(add_w);

  always_comb begin
    st.skip      = !sym_ok || full_cond;
    st.tt_hit    = tt_rd_r[NW];
    st.q_match   = ({1'b0, lenp_r} + (NW + 1)'(1)) == {1'b0, len_rd_r};
    st.p_zero    = (p_r == '0);
    st.is_new    = new_r;
    st.idx_last  = (idx_r == IW'(gsa_pkg::ALPHABET - 1));
    st.copy_last = (idx_r == IW'(gsa_pkg::ALPHABET));
    st.red_hit   = tt_rd_r[NW] && (tt_rd_r[NW-1:0] == q_r);
  end

  always_comb begin
    tt_we = 1'b0; tt_re = 1'b0; lnk_we = 1'b0; lnk_re = 1'b0;
    len_we = 1'b0; len_re = 1'b0;
    tt_waddr = '0; tt_raddr = '0; tt_wdata = '0;
    lnk_waddr = '0; lnk_raddr = '0; lnk_wdata = '0;
    len_waddr = '0; len_raddr = '0; len_wdata = '0;
    nodes_nxt = nodes_r; curnode_nxt = curnode_r; total_nxt = total_r;
    idx_nxt = idx_r; c_nxt = c_r; p_nxt = p_r; q_nxt = q_r; k_nxt = k_r;
    cur_nxt = cur_r; lenp_nxt = lenp_r; lencur_nxt = lencur_r;
    lnkcur_nxt = lnkcur_r; full_nxt = full_r; new_nxt = new_r;
    found_nxt = found_r;
    ro_node_nxt = ro_node_r; ro_nodes_nxt = ro_nodes_r;
    ro_total_nxt = ro_total_r; ro_full_nxt = ro_full_r;
    case (cmd.op)
      gsa_pkg::OP_CLR_ROOT: begin
        tt_we    = 1'b1;
        tt_waddr = gsa_pkg::tt_addr('0, idx_r);
        idx_nxt  = st.idx_last ? '0 : idx_r + IW'(1);
      end
      gsa_pkg::OP_START: begin
        c_nxt    = in_symbol;
        p_nxt    = p_start;
        full_nxt = sym_ok && full_cond;
        new_nxt  = 1'b0;
      end
      gsa_pkg::OP_READ_P: begin
        tt_re     = 1'b1;
        tt_raddr  = gsa_pkg::tt_addr(p_r, IW'(col_idx));
        len_re    = 1'b1;
        len_raddr = p_r;
      end
      gsa_pkg::OP_LATCH_P: begin
        lenp_nxt = (p_r == '0) ? '0 : len_rd_r;
        q_nxt    = tt_rd_r[NW-1:0];
      end
      gsa_pkg::OP_READ_Q: begin
        len_re    = 1'b1;
        len_raddr = q_r;
      end
      gsa_pkg::OP_Q_MATCH: begin
        if (new_r) lnkcur_nxt = q_r;
        else       curnode_nxt = q_r;
      end
      gsa_pkg::OP_NEW: begin
        cur_nxt    = nodes_r[NW-1:0];
        nodes_nxt  = nodes_r + CW'(1);
        lencur_nxt = lenp_inc;
        len_we     = 1'b1;
        len_waddr  = nodes_r[NW-1:0];
        len_wdata  = lenp_inc;
        lnkcur_nxt = '0;
        found_nxt  = 1'b1;
        new_nxt    = 1'b1;
        idx_nxt    = '0;
      end
      gsa_pkg::OP_CLR: begin
        tt_we    = 1'b1;
        tt_waddr = gsa_pkg::tt_addr(cur_r, idx_r);
        idx_nxt  = st.idx_last ? '0 : idx_r + IW'(1);
      end
      gsa_pkg::OP_WALK_SET: begin
        tt_we    = 1'b1;
        tt_waddr = gsa_pkg::tt_addr(p_r, IW'(col_idx));
        tt_wdata = {1'b1, cur_r};
        if (p_r == '0) begin
          found_nxt = 1'b0;
        end else begin
          lnk_re    = 1'b1;
          lnk_raddr = p_r;
        end
      end
      gsa_pkg::OP_FOLLOW: begin
        p_nxt = lnk_rd_r;
      end
      gsa_pkg::OP_CLONE: begin
        k_nxt     = nodes_r[NW-1:0];
        nodes_nxt = nodes_r + CW'(1);
        len_we    = 1'b1;
        len_waddr = nodes_r[NW-1:0];
        len_wdata = lenp_inc;
        lnk_re    = 1'b1;
        lnk_raddr = q_r;
        idx_nxt   = '0;
      end
      gsa_pkg::OP_CP_LNK: begin
        lnk_we    = 1'b1;
        lnk_waddr = k_r;
        lnk_wdata = lnk_rd_r;
      end
      gsa_pkg::OP_COPY: begin
        if (!st.copy_last) begin
          tt_re    = 1'b1;
          tt_raddr = gsa_pkg::tt_addr(q_r, idx_r);
        end
        if (idx_r != '0) begin
          tt_we    = 1'b1;
          tt_waddr = gsa_pkg::tt_addr(k_r, idx_r - IW'(1));
          tt_wdata = tt_rd_r;
        end
        idx_nxt = st.copy_last ? '0 : idx_r + IW'(1);
      end
      gsa_pkg::OP_RED_SET: begin
        tt_we    = 1'b1;
        tt_waddr = gsa_pkg::tt_addr(p_r, IW'(col_idx));
        tt_wdata = {1'b1, k_r};
        if (p_r != '0) begin
          lnk_re    = 1'b1;
          lnk_raddr = p_r;
        end
      end
      gsa_pkg::OP_RED_READ: begin
        tt_re    = 1'b1;
        tt_raddr = gsa_pkg::tt_addr(p_r, IW'(col_idx));
      end
      gsa_pkg::OP_RED_END: begin
        lnk_we    = 1'b1;
        lnk_waddr = q_r;
        lnk_wdata = k_r;
        if (new_r) lnkcur_nxt = k_r;
        else       curnode_nxt = k_r;
      end
      gsa_pkg::OP_TOT: begin
        lnk_we      = 1'b1;
        lnk_waddr   = cur_r;
        lnk_wdata   = lnkcur_r;
        total_nxt   = sum_w[TW] ? '1 : sum_w[TW-1:0];
        curnode_nxt = cur_r;
      end
      gsa_pkg::OP_LOAD: begin
        ro_node_nxt  = curnode_r;
        ro_nodes_nxt = nodes_r;
        ro_total_nxt = total_r;
        ro_full_nxt  = full_r;
      end
      default: begin
      end
    endcase
  end

  assign out_reached_node        = ro_node_r;
  assign out_nodes_used          = ro_nodes_r;
  assign out_distinct_substrings = ro_total_r;
  assign out_table_full          = ro_full_r;

  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= CW'(gsa_pkg::MAX_NODES))
    else $error("node count beyond store");
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == gsa_pkg::OP_TOT |-> {1'b0, cur_r} < nodes_r)
    else $error("new node outside allocated range");

endmodule
`default_nettype wire

### design/generalized_suffix_automaton_build_core.sv
// Flow: a followed edge reads the parent row and the target length, then loads the
//   result; a refused or ignored symbol goes straight to the result; an added node
//   clears its row and walks suffix links, and a clone copies a row and redirects.
// Throughput: one transaction at a time; the next input is taken the cycle after the
//   result loads; row clear and row copy dominate.
// Reset: synchronous, active low; afterward the root row's 26 entries are cleared
//   with input stalled.
`default_nettype none
module generalized_suffix_automaton_build_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gsa_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic                        in_first_of_string,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gsa_pkg::NODE_W-1:0]       out_reached_node,
  output logic [gsa_pkg::CNT_W-1:0]        out_nodes_used,
  output logic [gsa_pkg::TOT_W-1:0]        out_distinct_substrings,
  output logic                             out_table_full
);

  gsa_pkg::cmd_t    cmd;
  gsa_pkg::status_t st;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  gsa_dpath u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .st                      (st),
    .in_symbol               (in_symbol),
    .in_first_of_string      (in_first_of_string),
    .out_reached_node        (out_reached_node),
    .out_nodes_used          (out_nodes_used),
    .out_distinct_substrings (out_distinct_substrings),
    .out_table_full          (out_table_full)
  );

endmodule
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;

  localparam int MAX_NODES = gsa_pkg::MAX_NODES;
  localparam int ALPHABET  = gsa_pkg::ALPHABET;
  localparam int SYM_W     = gsa_pkg::SYM_W;
  localparam int NODE_W    = gsa_pkg::NODE_W;
  localparam int CNT_W     = gsa_pkg::CNT_W;
  localparam int TOT_W     = gsa_pkg::TOT_W;

  localparam int WATCH_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [CNT_W-1:0]  used;
    logic [TOT_W-1:0]  total;
    logic              full;
  } sam_result_t;

  class sam_scoreboard;
    bit [NODE_W-1:0] edge_to[MAX_NODES*ALPHABET];
    bit              edge_ok[MAX_NODES*ALPHABET];
    int              link[MAX_NODES];
    int              len[MAX_NODES];
    int              used;
    int              cur;
    int              total;
    sam_result_t     pending[$];
    int              errors;
    int              results_seen;
    int              refused;
    int              ignored;
    int              clones;

    function new();
      foreach (edge_ok[i]) edge_ok[i] = 0;
      link[0] = -1;
      len[0] = 0;
      used = 1;
      cur = 0;
      total = 0;
      errors = 0;
    endfunction

    function bit is_full();
      return used + 2 > MAX_NODES;
    endfunction

    function bit has(int n, int c);
      return edge_ok[n*ALPHABET+c];
    endfunction

    function int clone_at(int q, int p, int c, int nl);
      int k;
      k = used++;
      clones++;
      for (int i = 0; i < ALPHABET; i++) begin
        edge_to[k*ALPHABET+i] = edge_to[q*ALPHABET+i];
        edge_ok[k*ALPHABET+i] = edge_ok[q*ALPHABET+i];
      end
      link[k] = link[q];
      len[k] = nl;
      while (p != -1 && has(p, c) && edge_to[p*ALPHABET+c] == q) begin
        edge_to[p*ALPHABET+c] = NODE_W'(k);
        p = link[p];
      end
      link[q] = k;
      return k;
    endfunction

    function int extend(int p, int c);
      int q;
      int nn;
      int t;
      if (has(p, c)) begin
        q = edge_to[p*ALPHABET+c];
        if (len[p] + 1 == len[q]) return q;
        return clone_at(q, p, c, len[p] + 1);
      end
      nn = used++;
      for (int i = 0; i < ALPHABET; i++) edge_ok[nn*ALPHABET+i] = 0;
      len[nn] = len[p] + 1;
      link[nn] = 0;
      while (p != -1 && !has(p, c)) begin
        edge_to[p*ALPHABET+c] = NODE_W'(nn);
        edge_ok[p*ALPHABET+c] = 1;
        p = link[p];
      end
      if (p != -1) begin
        q = edge_to[p*ALPHABET+c];
        if (len[p] + 1 == len[q]) link[nn] = q;
        else link[nn] = clone_at(q, p, c, len[p] + 1);
      end
      t = total + len[nn] - len[link[nn]];
      total = (t > 4194303) ? 4194303 : t;
      return nn;
    endfunction

    function void note_symbol(logic [SYM_W-1:0] sym, logic first);
      sam_result_t r;
      r.full = 0;
      if (sym < ALPHABET) begin
        if (is_full()) begin
          r.full = 1;
          refused++;
        end else begin
          cur = extend(first ? 0 : cur, sym);
        end
      end else begin
        ignored++;
      end
      r.node = cur[NODE_W-1:0];
      r.used = used[CNT_W-1:0];
      r.total = total[TOT_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(sam_result_t a);
      sam_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result node=%0d", $time, a.node);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.node !== e.node) begin
        $display("%0t: reached_node exp %0d got %0d", $time, e.node, a.node);
        errors++;
      end
      if (a.used !== e.used) begin
        $display("%0t: nodes_used exp %0d got %0d", $time, e.used, a.used);
        errors++;
      end
      if (a.total !== e.total) begin
        $display("%0t: distinct_substrings exp %0d got %0d", $time, e.total, a.total);
        errors++;
      end
      if (a.full !== e.full) begin
        $display("%0t: table_full exp %0b got %0b", $time, e.full, a.full);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [SYM_W-1:0]  in_symbol;
  logic              in_first_of_string;
  logic              out_valid;
  logic              out_stall;
  logic [NODE_W-1:0] out_reached_node;
  logic [CNT_W-1:0]  out_nodes_used;
  logic [TOT_W-1:0]  out_distinct_substrings;
  logic              out_table_full;

  sam_scoreboard sb;
  int            send_gap_pct;
  int            stall_pct;
  int            quiet_cycles;
  int            sent;

  generalized_suffix_automaton_build_core i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_symbol               (in_symbol),
    .in_first_of_string      (in_first_of_string),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_reached_node        (out_reached_node),
    .out_nodes_used          (out_nodes_used),
    .out_distinct_substrings (out_distinct_substrings),
    .out_table_full          (out_table_full)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    sam_result_t a;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_symbol(in_symbol, in_first_of_string);
      if (out_valid && !out_stall) begin
        a.node = out_reached_node;
        a.used = out_nodes_used;
        a.total = out_distinct_substrings;
        a.full = out_table_full;
        sb.check_result(a);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_symbol(logic [SYM_W-1:0] sym, logic first);
    in_valid <= 1;
    in_symbol <= sym;
    in_first_of_string <= first;
    do @(posedge clk); while (in_stall);
    sent++;
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      in_symbol <= SYM_W'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_random(int n);
    int alpha;
    int left;
    left = 0;
    alpha = 2;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 40);
        case ($urandom_range(3))
          0: alpha = 2;
          1: alpha = 3;
          2: alpha = 5;
          default: alpha = 26;
        endcase
        if ($urandom_range(19) == 0) begin
          send_symbol(SYM_W'($urandom_range(26, 31)), 1'($urandom));
        end else begin
          send_symbol(SYM_W'($urandom_range(alpha - 1)), 1);
        end
      end else if ($urandom_range(29) == 0) begin
        send_symbol(SYM_W'($urandom_range(26, 31)), 1'($urandom));
      end else begin
        send_symbol(SYM_W'($urandom_range(alpha - 1)), $urandom_range(49) == 0);
      end
      if (left > 0) left--;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_symbol = 0;
    in_first_of_string = 0;
    out_stall = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    send_symbol(0, 1);
    send_symbol(0, 0);
    send_symbol(25, 0);
    send_symbol(31, 1);
    send_symbol(26, 0);
    send_symbol(1, 1);
    send_symbol(0, 0);
    send_symbol(1, 0);
    send_symbol(2, 1);
    send_symbol(1, 0);
    send_symbol(2, 0);
    send_symbol(1, 0);
    send_symbol(2, 0);
    send_symbol(0, 1);
    send_symbol(1, 0);
    send_symbol(0, 0);
    send_symbol(1, 0);
    send_symbol(25, 1);
    send_symbol(25, 0);
    send_symbol(16, 0);
    drain();

    send_gap_pct = 0;  stall_pct = 0;  send_random(390); drain();
    send_gap_pct = 53; stall_pct = 0;  send_random(390); drain();
    send_gap_pct = 0;  stall_pct = 53; send_random(390); drain();
    send_gap_pct = 17; stall_pct = 17; send_random(390); drain();

    send_gap_pct = 17; stall_pct = 17;
    send_symbol(3, 1);
    send_symbol(25, 0);
    send_symbol(0, 0);
    send_symbol(30, 1);
    send_symbol(16, 1);
    drain();

    $display("Sent %0d symbols, %0d results; %0d clones, %0d refused, %0d ignored.",
             sent, sb.results_seen, sb.clones, sb.refused, sb.ignored);
    $display("Final automaton: %0d nodes, %0d distinct substrings.", sb.used, sb.total);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
design/gsa_pkg.sv
design/gsa_ctrl.sv
design/gsa_dpath.sv
design/generalized_suffix_automaton_build_core.sv
tb/sv/tb.sv
